// ===== hdl/mvm_pkg.sv =====
// shared types, constants and binary32 helper functions for the matrix-vector block
// no dependencies
`default_nettype none
package mvm_pkg;

    localparam int MAX_VECTOR_LENGTH = 4096;
    localparam int VEC_AW            = $clog2(MAX_VECTOR_LENGTH);
    localparam int ROW_LIMIT         = 65536;
    localparam int ROW_W             = 16;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    // configuration register indexes
    localparam logic [1:0] CFG_VECTOR_LENGTH = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT     = 2'd1;

    // item operations
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_MATRIX = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] row_value;
        logic        last_row;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MNORM,
        S_MRND,
        S_ALIGN,
        S_ADD,
        S_ANORM,
        S_ARND
    } t_state;

    // index of the highest set bit of a 48-bit word
    function automatic logic [5:0] msb48(input logic [47:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

    // index of the highest set bit of a 50-bit word
    function automatic logic [5:0] msb50(input logic [49:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

    // right shift with the shifted-out bits folded into bit zero
    function automatic logic [49:0] shr_sticky50(input logic [49:0] v, input logic [7:0] d);
        logic [49:0] sh;
        logic        st;
        if (d >= 8'd50) begin
            sh = '0;
            st = |v;
        end else begin
            sh = v >> d;
            st = |(v & ~({50{1'b1}} << d));
        end
        return {sh[49:1], sh[0] | st};
    endfunction

    // round to nearest even and pack; m has its leading one at bit 47,
    // e is the biased exponent of that leading one
    function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                               input logic [47:0] m);
        logic [7:0]  d;
        logic [9:0]  ea;
        logic [47:0] sh;
        logic        st;
        logic [23:0] mt;
        logic        inc;
        logic [32:0] t;
        if (e >= 11'sd1) begin
            d  = 8'd0;
            ea = e[9:0] - 10'd1;
        end else begin
            d  = (e < -11'sd100) ? 8'd100 : 8'(11'sd1 - e);
            ea = 10'd0;
        end
        if (d >= 8'd48) begin
            sh = '0;
            st = |m;
        end else begin
            sh = m >> d;
            st = |(m & ~({48{1'b1}} << d));
        end
        mt  = sh[47:24];
        inc = sh[23] & (st | (|sh[22:0]) | mt[0]);
        t   = {ea, 23'b0} + {9'b0, mt} + {32'b0, inc};
        if (t[32:23] >= 10'd255) return {s, 8'hFF, 23'b0};
        return {s, t[30:0]};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/mvm_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none
module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== hdl/matrix_vector_multiply_f32.sv =====
// binary32 matrix-vector product: vector memory, multiply and add sequencer
// depends on mvm_pkg and mvm_ram
`default_nettype none
// Usage
//   Items enter on start/i_item while busy is low. op=0 writes the next vector
//   element into the vector memory; op=1 is the next matrix element, row by row.
//   Each matrix element is multiplied by the stored element of its column and
//   added into the row sum, both rounded to nearest even. After vector_length
//   elements the row sum appears on o_res for one cycle with o_res_valid high;
//   last_row marks the final row of row_count rows.
//   Configuration: i_cfg_valid with i_cfg_index/i_cfg_data, o_cfg_ready is
//   always high; index 0 is vector_length, index 1 is row_count.
// Timing
//   a load is written while busy stays low. A matrix element passes through
//   the memory read, then the multiply, normalize and round steps and the
//   align, add, normalize and round steps, all on one shared datapath. The
//   row result shows in the cycle after the last round step, when the next
//   item may already be taken.
// Reset
//   synchronous, active low: counters and the row sum clear, registers return
//   to vector_length 4096 and row_count 1; the vector memory is not cleared.
//   The receiver cannot stall, so results are never held.
module matrix_vector_multiply_f32 (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire mvm_pkg::t_in_item   i_item,
    output logic                     o_res_valid,
    output mvm_pkg::t_out_item       o_res,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data
);
    import mvm_pkg::*;

    t_state r_state, n_state;

    logic [12:0]       r_vlen;
    logic [16:0]       r_rows;
    logic [VEC_AW-1:0] r_load_pos;
    logic [VEC_AW-1:0] r_col_pos;
    logic [ROW_W-1:0]  r_row_pos;
    logic [31:0]       r_sum;
    logic [31:0]       r_value;

    // multiply path
    logic               r_m_nan, r_m_inf, r_m_zero, r_m_sign;
    logic [47:0]        r_m_p;
    logic signed [10:0] r_m_e;
    logic [47:0]        r_n_m;
    logic signed [10:0] r_n_e;
    logic [31:0]        r_prod;

    // add path
    logic               r_a_nan, r_a_inf, r_a_zero, r_a_sign, r_a_sub, r_a_isign;
    logic [49:0]        r_a_big, r_a_sml, r_a_sum;
    logic signed [10:0] r_a_e;
    logic               r_z_zero;
    logic [47:0]        r_z_m;
    logic signed [10:0] r_z_e;

    logic        r_out_valid;
    t_out_item   r_out;

    logic              accept, ram_we;
    logic [VEC_AW-1:0] ram_addr;
    logic [31:0]       ram_rdata;

    mvm_ram #(.WIDTH(32), .DEPTH(MAX_VECTOR_LENGTH)) u_vec_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(i_item.value),
        .o_rdata(ram_rdata)
    );

    // effective lengths after clamping
    logic [31:0]     vlen32, len32;
    logic [VEC_AW:0] eff_len;
    logic [16:0]     eff_rows;
    always_comb begin
        vlen32 = {19'b0, r_vlen};
        if (vlen32 == 32'd0) len32 = 32'd1;
        else if (vlen32 > 32'(MAX_VECTOR_LENGTH)) len32 = 32'(MAX_VECTOR_LENGTH);
        else len32 = vlen32;
        eff_len = len32[VEC_AW:0];
        if (r_rows == 17'd0) eff_rows = 17'd1;
        else if (r_rows > 17'(ROW_LIMIT)) eff_rows = 17'(ROW_LIMIT);
        else eff_rows = r_rows;
    end

    logic load_end, col_end, row_end;
    assign load_end = ({1'b0, r_load_pos} + 1'b1) >= eff_len;
    assign col_end  = ({1'b0, r_col_pos} + 1'b1) >= eff_len;
    assign row_end  = ({1'b0, r_row_pos} + 1'b1) >= eff_rows;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start && i_item.op == OP_MATRIX) n_state = S_MUL;
            S_MUL:   n_state = S_MNORM;
            S_MNORM: n_state = S_MRND;
            S_MRND:  n_state = S_ALIGN;
            S_ALIGN: n_state = S_ADD;
            S_ADD:   n_state = S_ANORM;
            S_ANORM: n_state = S_ARND;
            S_ARND:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        busy     = 1'b1;
        ram_we   = 1'b0;
        ram_addr = r_col_pos;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start && i_item.op == OP_LOAD) begin
                    ram_we   = 1'b1;
                    ram_addr = r_load_pos;
                end
            end
            default: busy = 1'b1;
        endcase
    end

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= 13'd4096;
            r_rows <= 17'd1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_VECTOR_LENGTH) r_vlen <= i_cfg_data[12:0];
            else if (i_cfg_index == CFG_ROW_COUNT) r_rows <= i_cfg_data[16:0];
        end
    end

    // multiply: decode, specials, mantissa product
    logic        ma_nan, ma_inf, ma_zero, mb_nan, mb_inf, mb_zero;
    logic [23:0] ma_m, mb_m;
    logic [7:0]  ma_e, mb_e;
    always_comb begin
        ma_e    = (ram_rdata[30:23] == 8'd0) ? 8'd1 : ram_rdata[30:23];
        mb_e    = (r_value[30:23] == 8'd0) ? 8'd1 : r_value[30:23];
        ma_m    = {ram_rdata[30:23] != 8'd0, ram_rdata[22:0]};
        mb_m    = {r_value[30:23] != 8'd0, r_value[22:0]};
        ma_nan  = (&ram_rdata[30:23]) && (|ram_rdata[22:0]);
        mb_nan  = (&r_value[30:23]) && (|r_value[22:0]);
        ma_inf  = (&ram_rdata[30:23]) && !(|ram_rdata[22:0]);
        mb_inf  = (&r_value[30:23]) && !(|r_value[22:0]);
        ma_zero = ram_rdata[30:0] == 31'd0;
        mb_zero = r_value[30:0] == 31'd0;
    end

    // add: decode, specials, swap and align
    logic        x_nan, x_inf, y_nan, y_inf, x_big;
    logic [31:0] ab, as;
    logic [7:0]  ab_e, as_e, ediff;
    always_comb begin
        x_nan = (&r_sum[30:23]) && (|r_sum[22:0]);
        y_nan = (&r_prod[30:23]) && (|r_prod[22:0]);
        x_inf = (&r_sum[30:23]) && !(|r_sum[22:0]);
        y_inf = (&r_prod[30:23]) && !(|r_prod[22:0]);
        x_big = r_sum[30:0] >= r_prod[30:0];
        ab    = x_big ? r_sum : r_prod;
        as    = x_big ? r_prod : r_sum;
        ab_e  = (ab[30:23] == 8'd0) ? 8'd1 : ab[30:23];
        as_e  = (as[30:23] == 8'd0) ? 8'd1 : as[30:23];
        ediff = ab_e - as_e;
    end

    // normalize the raw sum so its leading one sits at bit 49
    logic [5:0]  a_msb;
    logic [49:0] a_norm;
    always_comb begin
        a_msb  = msb50(r_a_sum);
        a_norm = r_a_sum << (6'd49 - a_msb);
    end

    // datapath registers, one step per state
    always_ff @(posedge i_clk) begin
        if (accept) r_value <= i_item.value;
        unique case (r_state)
            S_MUL: begin
                r_m_nan  <= ma_nan || mb_nan || (ma_inf && mb_zero) || (ma_zero && mb_inf);
                r_m_inf  <= ma_inf || mb_inf;
                r_m_zero <= ma_zero || mb_zero;
                r_m_sign <= ram_rdata[31] ^ r_value[31];
                r_m_p    <= ma_m * mb_m;
                r_m_e    <= 11'(signed'({3'b0, ma_e})) + 11'(signed'({3'b0, mb_e}))
                            - 11'sd173;
            end
            S_MNORM: begin
                r_n_m <= r_m_p << (6'd47 - msb48(r_m_p));
                r_n_e <= r_m_e + 11'(signed'({5'b0, msb48(r_m_p)}));
            end
            S_MRND: begin
                if (r_m_nan) r_prod <= CANON_NAN;
                else if (r_m_inf) r_prod <= {r_m_sign, 8'hFF, 23'b0};
                else if (r_m_zero) r_prod <= {r_m_sign, 31'b0};
                else r_prod <= round_pack(r_m_sign, r_n_e, r_n_m);
            end
            S_ALIGN: begin
                r_a_nan   <= x_nan || y_nan || (x_inf && y_inf && (r_sum[31] != r_prod[31]));
                r_a_inf   <= x_inf || y_inf;
                r_a_isign <= x_inf ? r_sum[31] : r_prod[31];
                r_a_zero  <= (r_sum[30:0] == 31'd0) && (r_prod[30:0] == 31'd0);
                r_a_sign  <= (r_sum[30:0] == 31'd0 && r_prod[30:0] == 31'd0)
                             ? (r_sum[31] & r_prod[31]) : ab[31];
                r_a_sub   <= r_sum[31] ^ r_prod[31];
                r_a_e     <= 11'(signed'({3'b0, ab_e}));
                r_a_big   <= {1'b0, ab[30:23] != 8'd0, ab[22:0], 25'b0};
                r_a_sml   <= shr_sticky50({1'b0, as[30:23] != 8'd0, as[22:0], 25'b0}, ediff);
            end
            S_ADD: begin
                r_a_sum <= r_a_sub ? (r_a_big - r_a_sml) : (r_a_big + r_a_sml);
            end
            S_ANORM: begin
                r_z_zero <= r_a_sum == 50'd0;
                r_z_e    <= r_a_e + 11'(signed'({5'b0, a_msb})) - 11'sd48;
                r_z_m    <= {a_norm[49:3], a_norm[2] | (|a_norm[1:0])};
            end
            default: ;
        endcase
    end

    // add result, counters and the row beat
    logic [31:0] add_res;
    always_comb begin
        if (r_a_nan) add_res = CANON_NAN;
        else if (r_a_inf) add_res = {r_a_isign, 8'hFF, 23'b0};
        else if (r_a_zero) add_res = {r_a_sign, 31'b0};
        else if (r_z_zero) add_res = 32'd0;
        else add_res = round_pack(r_a_sign, r_z_e, r_z_m);
    end

    always_ff @(posedge i_clk) begin
        r_out.row_value <= add_res;
        r_out.last_row  <= row_end;
        if (!i_rst_n) begin
            r_load_pos  <= '0;
            r_col_pos   <= '0;
            r_row_pos   <= '0;
            r_sum       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (ram_we) begin
                r_load_pos <= load_end ? '0 : r_load_pos + 1'b1;
            end
            if (r_state == S_ARND) begin
                if (col_end) begin
                    r_col_pos   <= '0;
                    r_sum       <= 32'd0;
                    r_out_valid <= 1'b1;
                    r_row_pos   <= row_end ? '0 : r_row_pos + 1'b1;
                end else begin
                    r_col_pos <= r_col_pos + 1'b1;
                    r_sum     <= add_res;
                end
            end
        end
    end

    // checks
    a_res_after_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(r_state) == S_ARND)
        else $error("row beat without a finished add");
    a_ram_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == S_IDLE)
        else $error("vector write while a product is in flight");
    a_matrix_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.op == OP_MATRIX) |=> busy)
        else $error("matrix beat did not start the datapath");
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> r_sum == 32'd0 && r_col_pos == '0)
        else $error("row sum not cleared after a row beat");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for matrix_vector_multiply_f32: directed table plus random phases
// depends on mvm_pkg and the block's rtl; binary32 arithmetic is predicted in integer form
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import mvm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int FILL_LEN       = 8;

    typedef struct packed {
        logic        op;
        logic [31:0] value;
        logic        typed;
        logic [31:0] want_value;
        logic        want_last;
    } t_dir_row;

    typedef struct packed {
        logic [12:0] len;
        logic [16:0] rows;
        int          items;
        int          matrix_pct;
    } t_phase;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_item   i_item;
    logic       o_res_valid;
    t_out_item  o_res;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    matrix_vector_multiply_f32 u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // mirror of the block's state and registers
    logic [31:0] vec_mirror [MAX_VECTOR_LENGTH];
    int unsigned load_pos, col_pos, row_pos;
    logic [31:0] row_sum;
    logic [12:0] len_reg;
    logic [16:0] rows_reg;

    t_out_item   row_sums_due [$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          burst;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // round to nearest even and pack; value is m * 2^x, m nonzero
    function automatic logic [31:0] pack_rne(input logic s, input int x, input logic [127:0] m);
        int          k, be, sh;
        logic [127:0] q, rem, half;
        logic [39:0] t;
        k = 0;
        for (int i = 0; i < 128; i++) begin
            if (m[i]) k = i;
        end
        be = x + k + 127;
        sh = (be >= 1) ? k - 23 : -149 - x;
        if (sh <= 0) begin
            q = m << (-sh);
        end else if (sh > 127) begin
            q = '0;
        end else begin
            q    = m >> sh;
            rem  = m & ((128'd1 << sh) - 128'd1);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) q = q + 128'd1;
        end
        t = (be >= 1) ? (40'(be - 1) << 23) + q[39:0] : q[39:0];
        if (t >= (40'd255 << 23)) return {s, 8'hFF, 23'b0};
        return {s, t[30:0]};
    endfunction

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 0);
    endfunction

    function automatic logic is_zero(input logic [31:0] a);
        return a[30:0] == 0;
    endfunction

    function automatic int exp_of(input logic [31:0] a);
        return ((a[30:23] == 0) ? 1 : int'(a[30:23])) - 150;
    endfunction

    function automatic logic [23:0] mant_of(input logic [31:0] a);
        return {a[30:23] != 0, a[22:0]};
    endfunction

    function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) return CANON_NAN;
        if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'b0};
        if (is_zero(a) || is_zero(b)) return {s, 31'b0};
        return pack_rne(s, exp_of(a) + exp_of(b), 128'(mant_of(a)) * 128'(mant_of(b)));
    endfunction

    function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]  big, tiny;
        int           xl, d;
        logic [127:0] ml, ms, m;
        logic         s;
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return CANON_NAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'b0};
        if (is_zero(a)) return b;
        if (is_zero(b)) return a;
        if (exp_of(a) >= exp_of(b)) begin
            big = a; tiny = b;
        end else begin
            big = b; tiny = a;
        end
        xl = exp_of(big);
        d  = xl - exp_of(tiny);
        ms = 128'(mant_of(tiny));
        // far below the rounding point the smaller operand only acts as sticky
        if (d > 60) begin
            ms = 128'd1;
            d  = 60;
        end
        ml = 128'(mant_of(big)) << d;
        if (big[31] == tiny[31]) begin
            m = ml + ms; s = big[31];
        end else if (ml > ms) begin
            m = ml - ms; s = big[31];
        end else if (ml < ms) begin
            m = ms - ml; s = tiny[31];
        end else begin
            return 32'h0;
        end
        return pack_rne(s, xl - d, m);
    endfunction

    // one item through the mirror; a finished row gives a row sum
    task automatic mvm_step(input logic op, input logic [31:0] value,
                            output bit got, output t_out_item res);
        int unsigned len, rows;
        len  = (len_reg == 0) ? 1 : ((len_reg > MAX_VECTOR_LENGTH) ? MAX_VECTOR_LENGTH : len_reg);
        rows = (rows_reg == 0) ? 1 : ((rows_reg > ROW_LIMIT) ? ROW_LIMIT : rows_reg);
        got  = 1'b0;
        res  = '0;
        if (op == OP_LOAD) begin
            vec_mirror[load_pos % MAX_VECTOR_LENGTH] = value;
            load_pos = (load_pos + 1 >= len) ? 0 : load_pos + 1;
        end else begin
            row_sum = f32_add(row_sum, f32_mul(vec_mirror[col_pos % MAX_VECTOR_LENGTH], value));
            if (col_pos + 1 < len) begin
                col_pos = col_pos + 1;
            end else begin
                col_pos       = 0;
                got           = 1'b1;
                res.row_value = row_sum;
                row_sum       = 32'h0;
                res.last_row  = (row_pos + 1 >= rows);
                row_pos       = res.last_row ? 0 : row_pos + 1;
            end
        end
    endtask

    function automatic logic [31:0] rand_f32();
        logic [31:0] specials [8];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0001, 32'h7F7F_FFFF, 32'h0000_0001, 32'h807F_FFFF};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return {1'($urandom), 8'($urandom_range(110, 144)), 23'($urandom)};
            5, 6:          return $urandom;
            7:             return specials[$urandom_range(0, 7)];
            8:             return {1'($urandom), 8'h00, 23'($urandom)};
            default:       return {1'($urandom), 8'($urandom_range(200, 254)), 23'($urandom)};
        endcase
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // drive one beat after a random gap; optionally replace the predicted row sum
    task automatic send(input logic op, input logic [31:0] value,
                        input logic typed, input t_out_item typed_res);
        int        gap;
        bit        got;
        t_out_item res;
        if ($urandom_range(0, 39) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 19);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{op: op, value: value};
        do @(posedge i_clk); while (busy);
        mvm_step(op, value, got, res);
        if (got) row_sums_due.push_back(typed ? typed_res : res);
    endtask

    // register write once every row sum is out and the datapath has settled
    task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
        @(negedge i_clk);
        start <= 1'b0;
        while (row_sums_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_VECTOR_LENGTH) len_reg = data[12:0];
        else rows_reg = data[16:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result check against the oldest expected row sum
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_res_valid) begin
            if (row_sums_due.size() == 0) begin
                report("unexpected row sum", o_res.row_value, 32'h0);
            end else begin
                want = row_sums_due.pop_front();
                if (o_res.row_value !== want.row_value)
                    report("row_value", o_res.row_value, want.row_value);
                if (o_res.last_row !== want.last_row)
                    report("last_row", 32'(o_res.last_row), 32'(want.last_row));
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    t_dir_row dir_rows [12];
    t_phase   phases [8];

    initial begin
        t_out_item tr;
        logic      op;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_VECTOR_LENGTH;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        burst       = 1'b0;
        len_reg     = 13'd4096;
        rows_reg    = 17'd1;
        load_pos    = 0;
        col_pos     = 0;
        row_pos     = 0;
        row_sum     = 32'h0;

        // vector 1.0 then specials; vector length 1, two rows per product
        dir_rows = '{
            '{OP_LOAD,   32'h3F80_0000, 1'b0, 32'h0,          1'b0},
            '{OP_MATRIX, 32'h7F7F_FFFF, 1'b1, 32'h7F7F_FFFF, 1'b0},
            '{OP_MATRIX, 32'hFF80_0000, 1'b1, 32'hFF80_0000, 1'b1},
            '{OP_MATRIX, 32'h7FFF_FFFF, 1'b1, CANON_NAN,     1'b0},
            '{OP_MATRIX, 32'h0000_0001, 1'b1, 32'h0000_0001, 1'b1},
            '{OP_MATRIX, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0},
            '{OP_LOAD,   32'h0000_0000, 1'b0, 32'h0,          1'b0},
            '{OP_MATRIX, 32'h7F80_0000, 1'b1, CANON_NAN,     1'b1},
            '{OP_LOAD,   32'h7F7F_FFFF, 1'b0, 32'h0,          1'b0},
            '{OP_MATRIX, 32'h4000_0000, 1'b1, 32'h7F80_0000, 1'b0},
            '{OP_LOAD,   32'h0080_0000, 1'b0, 32'h0,          1'b0},
            '{OP_MATRIX, 32'h3E80_0000, 1'b1, 32'h0020_0000, 1'b1}
        };
        // out-of-range values are clamped by the block; the long vector phase
        // only loads, so matrix reads stay within the filled entries
        phases = '{
            '{13'd3,    17'd4,      200, 80},
            '{13'd0,    17'd0,      100, 70},
            '{13'd6,    17'd131071, 200, 80},
            '{13'd8191, 17'd1,      250, 0},
            '{13'd5,    17'd65536,  200, 80},
            '{13'd2,    17'd3,      200, 75},
            '{13'd1,    17'd1,      100, 60},
            '{13'd7,    17'd2,      230, 85}
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill every entry a row can reach, leaving the load position at zero
        write_reg(CFG_VECTOR_LENGTH, 32'(FILL_LEN));
        for (int i = 0; i < FILL_LEN; i++) send(OP_LOAD, rand_f32(), 1'b0, '0);

        write_reg(CFG_VECTOR_LENGTH, 32'd1);
        write_reg(CFG_ROW_COUNT, 32'd2);
        foreach (dir_rows[i]) begin
            tr.row_value = dir_rows[i].want_value;
            tr.last_row  = dir_rows[i].want_last;
            send(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, tr);
        end
        // rounding tie to negative zero, checked by prediction
        send(OP_LOAD, 32'h8000_0001, 1'b0, '0);
        send(OP_MATRIX, 32'h3F00_0000, 1'b0, '0);

        // random phases; register writes land mid-row on purpose
        foreach (phases[p]) begin
            write_reg(CFG_VECTOR_LENGTH, 32'(phases[p].len));
            write_reg(CFG_ROW_COUNT, 32'(phases[p].rows));
            for (int i = 0; i < phases[p].items; i++) begin
                op = ($urandom_range(0, 99) < phases[p].matrix_pct) ? OP_MATRIX : OP_LOAD;
                send(op, rand_f32(), 1'b0, '0);
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (row_sums_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
